// ===== sv/apst_pkg.sv =====
// ----------------------------------------------------------------------------
// apst_pkg
// shared types and codes for the ack pending slot table
// ----------------------------------------------------------------------------
package apst_pkg;

  // action codes carried by an input item
  localparam logic [2:0] ACT_CLAIM   = 3'd0;
  localparam logic [2:0] ACT_MARK    = 3'd1;
  localparam logic [2:0] ACT_FREE    = 3'd2;
  localparam logic [2:0] ACT_ACK     = 3'd3;
  localparam logic [2:0] ACT_EXPIRE  = 3'd4;
  localparam logic [2:0] ACT_RELEASE = 3'd5;

  // status codes of a result
  localparam logic ST_OK   = 1'b0;
  localparam logic ST_FAIL = 1'b1;

  // register index (word address bit)
  localparam logic REG_TIMEOUT = 1'b0;

  localparam logic [31:0] TIMEOUT_RESET = 32'd5000;

  typedef struct packed {
    logic [2:0]  action;
    logic [3:0]  slot_index;
    logic [31:0] ack_id;
    logic [31:0] now_ticks;
  } apst_in_t;

  typedef struct packed {
    logic        status;
    logic [3:0]  result_slot;
    logic [31:0] result_seq;
    logic [31:0] round_trip_ticks;
    logic [4:0]  used_slots;
    logic        last;
  } apst_out_t;

  // contents of one slot
  typedef struct packed {
    logic        used;
    logic        awaiting;
    logic [31:0] seq;
    logic [31:0] sent;
  } slot_rec_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_REPORT,
    S_EXPIRE
  } apst_state_t;

endpackage

// ===== sv/ack_pending_slot_table_unit.sv =====
// ----------------------------------------------------------------------------
// ack_pending_slot_table_unit
// table of retransmit slots tracked until acknowledged or expired
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. The slots sit in a
// ring of cells that rotates by one place per cycle while the sequencer scans
// or hands out expired slots, so the sequencer sees each slot once at the head
// of the ring and edits it on its way to the tail. Claim, mark sent, free,
// ack, release, an unknown action and an expire scan with nothing expired
// take a rotation of the ring and then the report state before the next
// possible start, and give one result. An expire scan that frees slots needs
// a second rotation to hand them out, with one result per expired slot in
// ascending slot order and last set on the final one. Each result is marked
// by result_valid for exactly one cycle; the receiver cannot stall and must
// take it then.
// timeout_ticks is written through the APB port at byte address 0 (reset
// 5000) and should only be written while busy is low.
// ----------------------------------------------------------------------------
module ack_pending_slot_table_unit
  import apst_pkg::*;
#(
  parameter int SLOT_COUNT = 16
)
(
  input  logic        clk,
  input  logic        rst,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // command side
  input  logic        start,
  output logic        busy,
  input  apst_in_t    item,
  // result side
  output logic        result_valid,
  output apst_out_t   result
);

  logic [31:0] timeout_ticks;
  logic        reg_sel;

  // ring of slot records, chain[0] is the head seen by the sequencer
  slot_rec_t   chain [SLOT_COUNT];
  slot_rec_t   tail;
  logic        shift;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == REG_TIMEOUT);

  // register write on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      timeout_ticks <= pwdata;
    end
  end

  // reads outside the register map return zero
  assign prdata = reg_sel ? timeout_ticks : 32'd0;

  // slot cells, each takes its upper neighbor; the edited head enters the top
  for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
    if (i == SLOT_COUNT - 1) begin : g_top
      apst_cell u_cell (
        .clk    (clk),
        .rst    (rst),
        .shift  (shift),
        .rec_in (tail),
        .rec    (chain[i])
      );
    end else begin : g_mid
      apst_cell u_cell (
        .clk    (clk),
        .rst    (rst),
        .shift  (shift),
        .rec_in (chain[i+1]),
        .rec    (chain[i])
      );
    end
  end

  // scan sequencer: claim, ack match, expiry and result sequencing
  apst_ctrl #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .timeout      (timeout_ticks),
    .head         (chain[0]),
    .shift        (shift),
    .tail         (tail),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

// ===== sv/apst_cell.sv =====
// ----------------------------------------------------------------------------
// apst_cell
// one slot of the table; takes its neighbor's record on every shift
// ----------------------------------------------------------------------------
module apst_cell
  import apst_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      shift,
  input  slot_rec_t rec_in,
  output slot_rec_t rec
);

  always_ff @(posedge clk) begin
    if (rst) begin
      rec <= '0;
    end else if (shift) begin
      rec <= rec_in;
    end
  end

endmodule

// ===== sv/apst_ctrl.sv =====
// ----------------------------------------------------------------------------
// apst_ctrl
// scan sequencer: edits the record at the head of the ring as it passes
// ----------------------------------------------------------------------------
module apst_ctrl
  import apst_pkg::*;
#(
  parameter int SLOT_COUNT = 16
)
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  apst_in_t    item,
  input  logic [31:0] timeout,
  input  slot_rec_t   head,
  output logic        shift,
  output slot_rec_t   tail,
  output logic        result_valid,
  output apst_out_t   result
);

  localparam int PW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int UW = $clog2(SLOT_COUNT + 1);
  localparam logic [PW-1:0] POS_LAST = PW'(SLOT_COUNT - 1);
  localparam logic [31:0] SLOTS_W = 32'(SLOT_COUNT);

  apst_state_t state, state_next;

  logic [PW-1:0]         pos;
  logic [2:0]            act;
  logic [3:0]            idx;
  logic [31:0]           ack_id_r;
  logic [31:0]           now_r;
  logic                  found;
  logic [31:0]           next_seq;
  logic [UW-1:0]         used_cnt;
  logic [UW-1:0]         remaining;
  logic [SLOT_COUNT-1:0] hit_mask;
  logic [3:0]            res_slot;
  logic [31:0]           res_seq;
  logic [31:0]           res_rtt;

  logic [31:0] pos_w;
  logic [31:0] used_w;
  logic [31:0] age;
  logic        pos_last;
  logic        idx_ok;
  logic        at_idx;
  logic        is_wait;
  logic        claim_hit;
  logic        ack_hit;
  logic        idx_hit;
  logic        exp_hit;
  logic        drop;
  logic        res_fire;
  apst_out_t   res_next;

  assign pos_w    = 32'(pos);
  assign used_w   = 32'(used_cnt);
  assign age      = now_r - head.sent;
  assign pos_last = (pos == POS_LAST);
  assign idx_ok   = (32'(idx) < SLOTS_W);
  assign at_idx   = (pos_w == 32'(idx));
  assign is_wait  = head.used && head.awaiting;
  assign busy     = (state != S_IDLE);
  assign shift    = (state == S_SCAN) || (state == S_EXPIRE);

  // per-slot edit of the passing record
  always_comb begin
    tail      = head;
    claim_hit = 1'b0;
    ack_hit   = 1'b0;
    idx_hit   = 1'b0;
    exp_hit   = 1'b0;
    drop      = 1'b0;
    if (state == S_SCAN) begin
      case (act)
        ACT_CLAIM: begin
          if (!found && !head.used) begin
            claim_hit     = 1'b1;
            tail.used     = 1'b1;
            tail.awaiting = 1'b0;
            tail.seq      = next_seq;
          end
        end
        ACT_MARK: begin
          if (at_idx && idx_ok) begin
            idx_hit       = 1'b1;
            tail.awaiting = 1'b1;
            tail.sent     = now_r;
          end
        end
        ACT_FREE: begin
          if (at_idx && idx_ok) begin
            idx_hit   = 1'b1;
            tail.used = 1'b0;
            drop      = head.used;
          end
        end
        ACT_ACK: begin
          if (!found && is_wait && (head.seq == ack_id_r)) begin
            ack_hit   = 1'b1;
            tail.used = 1'b0;
            drop      = 1'b1;
          end
        end
        ACT_EXPIRE: begin
          if (is_wait && (age >= timeout)) begin
            exp_hit   = 1'b1;
            tail.used = 1'b0;
            drop      = 1'b1;
          end
        end
        ACT_RELEASE: begin
          if (is_wait) begin
            tail.used = 1'b0;
            drop      = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (pos_last) begin
          if ((act == ACT_EXPIRE) && ((remaining != '0) || exp_hit)) begin
            state_next = S_EXPIRE;
          end else begin
            state_next = S_REPORT;
          end
        end
      end
      S_REPORT: state_next = S_IDLE;
      S_EXPIRE: begin
        if (pos_last) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // result of the current cycle
  always_comb begin
    res_fire                  = 1'b0;
    res_next.status           = ST_FAIL;
    res_next.result_slot      = res_slot;
    res_next.result_seq       = res_seq;
    res_next.round_trip_ticks = res_rtt;
    res_next.used_slots       = used_w[4:0];
    res_next.last             = 1'b1;
    case (state)
      S_REPORT: begin
        res_fire = 1'b1;
        case (act)
          ACT_CLAIM:   res_next.status = found ? ST_OK : ST_FAIL;
          ACT_MARK:    res_next.status = idx_ok ? ST_OK : ST_FAIL;
          ACT_FREE:    res_next.status = idx_ok ? ST_OK : ST_FAIL;
          ACT_ACK:     res_next.status = found ? ST_OK : ST_FAIL;
          ACT_RELEASE: res_next.status = ST_OK;
          default:     res_next.status = ST_FAIL;
        endcase
      end
      S_EXPIRE: begin
        res_fire                  = hit_mask[pos];
        res_next.status           = ST_OK;
        res_next.result_slot      = pos_w[3:0];
        res_next.result_seq       = head.seq;
        res_next.round_trip_ticks = age;
        res_next.last             = (remaining == UW'(1));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      next_seq     <= '0;
      used_cnt     <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= res_fire;
      if (claim_hit) begin
        next_seq <= next_seq + 32'd1;
        used_cnt <= used_cnt + UW'(1);
      end else if (drop) begin
        used_cnt <= used_cnt - UW'(1);
      end
    end
  end

  // item fields and scan bookkeeping
  always_ff @(posedge clk) begin
    if (res_fire) result <= res_next;
    case (state)
      S_IDLE: begin
        if (start) begin
          act       <= item.action;
          idx       <= item.slot_index;
          ack_id_r  <= item.ack_id;
          now_r     <= item.now_ticks;
          pos       <= '0;
          found     <= 1'b0;
          hit_mask  <= '0;
          remaining <= '0;
          res_seq   <= '0;
          res_rtt   <= '0;
          res_slot  <= ((item.action == ACT_MARK) || (item.action == ACT_FREE)) ?
                       item.slot_index : 4'd0;
        end
      end
      S_SCAN: begin
        pos <= pos_last ? '0 : pos + PW'(1);
        if (claim_hit || ack_hit) begin
          found    <= 1'b1;
          res_slot <= pos_w[3:0];
          res_seq  <= claim_hit ? next_seq : head.seq;
        end
        if (ack_hit) res_rtt <= age;
        if (idx_hit) res_seq <= head.seq;
        if (exp_hit) begin
          hit_mask[pos] <= 1'b1;
          remaining     <= remaining + UW'(1);
        end
      end
      S_EXPIRE: begin
        pos <= pos_last ? '0 : pos + PW'(1);
        if (hit_mask[pos]) remaining <= remaining - UW'(1);
      end
      default: ;
    endcase
  end

endmodule

// ===== tb/sv/slot_table_checker.sv =====
// ----------------------------------------------------------------------------
// slot_table_checker
// watches the command, result and register ports of the ack pending slot
// table, keeps its own copy of the slot table and compares every result
// ----------------------------------------------------------------------------
module slot_table_checker
  import apst_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  input  logic        start,
  input  logic        busy,
  input  apst_in_t    item,
  input  logic        result_valid,
  input  apst_out_t   result,
  output int          errors,
  output int          results_due
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 16;
  localparam logic [2:0] TIMEOUT_ADDR = {REG_TIMEOUT, 2'b00};
  localparam int PRINT_CAP = 200;

  // predicted slot table
  logic        tbl_used    [SLOTS];
  logic        tbl_waiting [SLOTS];
  logic [31:0] tbl_seq     [SLOTS];
  logic [31:0] tbl_sent    [SLOTS];
  logic [31:0] seq_next;
  logic [31:0] timeout_cfg;

  // results owed by the block, oldest first
  apst_out_t due_results [$];

  function automatic logic [4:0] used_count();
    logic [4:0] n;
    n = '0;
    for (int k = 0; k < SLOTS; k++)
      if (tbl_used[k]) n = n + 5'd1;
    return n;
  endfunction

  function automatic string show(input apst_out_t r);
    return $sformatf("status=%0b slot=%0d seq=%h rtt=%h used=%0d last=%0b",
                     r.status, r.result_slot, r.result_seq, r.round_trip_ticks,
                     r.used_slots, r.last);
  endfunction

  task automatic report_mismatch(input string msg);
    if (errors < PRINT_CAP) $display("%0t ns  mismatch: %s", $time, msg);
    errors = errors + 1;
  endtask

  // update the table for one item and queue the results it owes
  task automatic apply_command(input apst_in_t cmd);
    apst_out_t   r;
    logic [31:0] age [SLOTS];
    logic        hit [SLOTS];
    int          found;
    int          hits;
    int          n;
    logic [4:0]  used;
    r = '0;
    r.last = 1'b1;
    found = -1;
    hits = 0;
    n = 0;
    case (cmd.action)
      ACT_CLAIM: begin
        for (int k = 0; k < SLOTS; k++)
          if (!tbl_used[k] && found < 0) found = k;
        if (found < 0) begin
          r.status = ST_FAIL;
        end else begin
          tbl_used[found] = 1'b1;
          tbl_waiting[found] = 1'b0;
          tbl_seq[found] = seq_next;
          seq_next = seq_next + 32'd1;
          r.status = ST_OK;
          r.result_slot = found[3:0];
          r.result_seq = tbl_seq[found];
        end
        r.used_slots = used_count();
        due_results.push_back(r);
      end
      ACT_MARK, ACT_FREE: begin
        // the 4-bit index always lands inside a 16-slot table
        if (cmd.action == ACT_MARK) begin
          tbl_waiting[cmd.slot_index] = 1'b1;
          tbl_sent[cmd.slot_index] = cmd.now_ticks;
        end else begin
          tbl_used[cmd.slot_index] = 1'b0;
        end
        r.status = ST_OK;
        r.result_slot = cmd.slot_index;
        r.result_seq = tbl_seq[cmd.slot_index];
        r.used_slots = used_count();
        due_results.push_back(r);
      end
      ACT_ACK: begin
        for (int k = 0; k < SLOTS; k++)
          if (found < 0 && tbl_used[k] && tbl_waiting[k] && tbl_seq[k] == cmd.ack_id)
            found = k;
        if (found < 0) begin
          r.status = ST_FAIL;
        end else begin
          tbl_used[found] = 1'b0;
          r.status = ST_OK;
          r.result_slot = found[3:0];
          r.result_seq = tbl_seq[found];
          r.round_trip_ticks = cmd.now_ticks - tbl_sent[found];
        end
        r.used_slots = used_count();
        due_results.push_back(r);
      end
      ACT_EXPIRE: begin
        for (int k = 0; k < SLOTS; k++) begin
          age[k] = cmd.now_ticks - tbl_sent[k];
          hit[k] = tbl_used[k] && tbl_waiting[k] && (age[k] >= timeout_cfg);
          if (hit[k]) begin
            tbl_used[k] = 1'b0;
            hits++;
          end
        end
        used = used_count();
        if (hits == 0) begin
          r.status = ST_FAIL;
          r.used_slots = used;
          due_results.push_back(r);
        end else begin
          for (int k = 0; k < SLOTS; k++) begin
            if (hit[k]) begin
              r.status = ST_OK;
              r.result_slot = 4'(k);
              r.result_seq = tbl_seq[k];
              r.round_trip_ticks = age[k];
              r.used_slots = used;
              r.last = (n + 1 == hits);
              due_results.push_back(r);
              n++;
            end
          end
        end
      end
      ACT_RELEASE: begin
        for (int k = 0; k < SLOTS; k++)
          if (tbl_used[k] && tbl_waiting[k]) tbl_used[k] = 1'b0;
        r.status = ST_OK;
        r.used_slots = used_count();
        due_results.push_back(r);
      end
      default: begin
        r.status = ST_FAIL;
        r.used_slots = used_count();
        due_results.push_back(r);
      end
    endcase
  endtask

  task automatic check_result(input apst_out_t got);
    apst_out_t want;
    if (due_results.size() == 0) begin
      report_mismatch({"result with nothing owed: ", show(got)});
    end else begin
      want = due_results.pop_front();
      if (got.status !== want.status || got.result_slot !== want.result_slot ||
          got.result_seq !== want.result_seq ||
          got.round_trip_ticks !== want.round_trip_ticks ||
          got.used_slots !== want.used_slots || got.last !== want.last)
        report_mismatch({"got ", show(got), " want ", show(want)});
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < SLOTS; k++) begin
        tbl_used[k] = 1'b0;
        tbl_waiting[k] = 1'b0;
        tbl_seq[k] = '0;
        tbl_sent[k] = '0;
      end
      seq_next = '0;
      timeout_cfg = TIMEOUT_RESET;
      due_results.delete();
      results_due = 0;
    end else begin
      // results first: they belong to items taken at earlier edges
      if (result_valid !== 1'b0) check_result(result);
      if (start === 1'b1 && busy === 1'b0) apply_command(item);
      if (psel && penable && pready && paddr == TIMEOUT_ADDR) begin
        if (pwrite) timeout_cfg = pwdata;
        else if (prdata !== timeout_cfg)
          report_mismatch($sformatf("timeout read %h want %h", prdata, timeout_cfg));
      end
      results_due = due_results.size();
    end
  end

endmodule

// ===== tb/sv/ack_pending_slot_table_unit_test.sv =====
// ----------------------------------------------------------------------------
// ack_pending_slot_table_unit_test
// drives claims, sends, acks, expiry scans and timeout settings into the
// slot table and reports the verdict of the checker beside it
// ----------------------------------------------------------------------------
module ack_pending_slot_table_unit_test
  import apst_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] TIMEOUT_ADDR = {REG_TIMEOUT, 2'b00};
  // action codes the block does not know
  localparam logic [2:0] ACT_UNUSED_LO = 3'd6;
  localparam logic [2:0] ACT_UNUSED_HI = 3'd7;
  // longest busy stretch is an expire that frees slots
  localparam int DRAIN_CYCLES = 40;
  localparam int LIMIT = 200000;
  localparam int PHASES = 5;
  localparam int SINGLES_PER_PHASE = 40;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        start;
  logic        busy;
  apst_in_t    item;
  logic        result_valid;
  apst_out_t   result;

  int          mismatches;
  int          results_due;
  int          cycle_count;

  // stimulus bookkeeping
  logic [31:0] tick;         // running tick count, wraps during the run
  logic [31:0] id_guess;     // claims issued so far, a rough next sequence id
  logic [31:0] cur_timeout;
  logic        idle_on;

  ack_pending_slot_table_unit dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .result_valid (result_valid),
    .result       (result)
  );

  slot_table_checker table_chk (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .result_valid (result_valid),
    .result       (result),
    .errors       (mismatches),
    .results_due  (results_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run guard: a hung block ends here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("** ack_pending_slot_table_unit: FAILED **");
      $finish;
    end
  end

  function automatic apst_in_t make_cmd(input logic [2:0] act, input logic [3:0] slot,
                                        input logic [31:0] id, input logic [31:0] now);
    apst_in_t c;
    c.action = act;
    c.slot_index = slot;
    c.ack_id = id;
    c.now_ticks = now;
    return c;
  endfunction

  // present one item, hold it until taken, then maybe go idle for a burst
  task automatic issue(input apst_in_t cmd);
    @(negedge clk);
    start = 1'b1;
    item = cmd;
    do @(posedge clk); while (busy !== 1'b0);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      start = 1'b0;
      // half the bursts start only once the block is free again
      if ($urandom_range(0, 1) == 1) begin
        do @(posedge clk); while (busy !== 1'b0);
      end
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // stop sending and wait until every owed result is in
  task automatic settle();
    @(negedge clk);
    start = 1'b0;
    wait (results_due == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // one apb transfer: setup cycle, then access cycle until pready
  task automatic reg_access(input logic wr, input logic [2:0] addr,
                            input logic [31:0] data);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = wr;
    paddr = addr;
    pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // new timeout only with the block idle, read back for the checker
  task automatic set_timeout(input logic [31:0] value);
    settle();
    reg_access(1'b1, TIMEOUT_ADDR, value);
    reg_access(1'b0, TIMEOUT_ADDR, '0);
    cur_timeout = value;
  endtask

  // empty the table, fill it past full, send every slot at one time and
  // scan exactly one timeout later so that all sixteen expire together
  task automatic flood();
    logic [31:0] t0;
    logic        descending;
    t0 = tick;
    descending = $urandom_range(0, 1);
    for (int s = 0; s < 16; s++)
      issue(make_cmd(ACT_FREE, 4'(s), $urandom(), t0));
    for (int s = 0; s < 17; s++)
      issue(make_cmd(ACT_CLAIM, 4'($urandom_range(0, 15)), $urandom(), $urandom()));
    id_guess = id_guess + 32'd16;
    for (int s = 0; s < 16; s++)
      issue(make_cmd(ACT_MARK, descending ? 4'(15 - s) : 4'(s), $urandom(), t0));
    tick = t0 + cur_timeout;
    issue(make_cmd(ACT_EXPIRE, 4'($urandom_range(0, 15)), $urandom(), tick));
  endtask

  // one random item, weighted toward claim, send and ack traffic
  task automatic random_single(input int step);
    apst_in_t cmd;
    int       pick;
    cmd = make_cmd(ACT_CLAIM, 4'($urandom_range(0, 15)), $urandom(), tick);
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      id_guess = id_guess + 32'd1;
    end else if (pick < 45) begin
      cmd.action = ACT_MARK;
      // claims land on low slots, so aim there often
      if ($urandom_range(0, 1) == 1) cmd.slot_index = 4'($urandom_range(0, 5));
    end else if (pick < 53) begin
      cmd.action = ACT_FREE;
    end else if (pick < 75) begin
      cmd.action = ACT_ACK;
      // mostly ids of recent claims, sometimes any id at all
      if ($urandom_range(0, 7) != 0) cmd.ack_id = id_guess - $urandom_range(1, 12);
    end else if (pick < 88) begin
      cmd.action = ACT_EXPIRE;
    end else if (pick < 94) begin
      cmd.action = ACT_RELEASE;
    end else begin
      cmd.action = ($urandom_range(0, 1) == 1) ? ACT_UNUSED_HI : ACT_UNUSED_LO;
    end
    // the odd item jumps to a random time, backward as often as forward
    if ($urandom_range(0, 19) == 0) cmd.now_ticks = $urandom();
    issue(cmd);
    tick = tick + $urandom_range(0, step);
  endtask

  initial begin
    logic [31:0] timeout_pick;
    int          step;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    start = 1'b0;
    item = '0;
    cycle_count = 0;
    idle_on = 1'b1;
    tick = 32'hFFFF_0000;
    id_guess = '0;
    cur_timeout = TIMEOUT_RESET;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // timeout after reset
    reg_access(1'b0, TIMEOUT_ADDR, '0);

    // directed: three claims, sends around the tick wrap, acks
    issue(make_cmd(ACT_CLAIM, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    issue(make_cmd(ACT_CLAIM, 4'd0, 32'd0, 32'd0));
    issue(make_cmd(ACT_CLAIM, 4'd7, 32'h5555_5555, 32'hAAAA_AAAA));
    issue(make_cmd(ACT_MARK, 4'd0, 32'd0, 32'd0));
    issue(make_cmd(ACT_MARK, 4'd1, 32'd0, 32'hFFFF_FF00));
    issue(make_cmd(ACT_MARK, 4'd2, 32'd0, 32'd1000));
    // round trip across the wrap of the tick count
    issue(make_cmd(ACT_ACK, 4'd0, 32'd1, 32'h0000_0100));
    // id not matched
    issue(make_cmd(ACT_ACK, 4'd0, 32'hFFFF_FFFF, 32'd0));
    // one tick short of the timeout: nothing expired
    issue(make_cmd(ACT_EXPIRE, 4'd0, 32'd0, 32'd4999));
    // two slots expire, one of them exactly at the timeout
    issue(make_cmd(ACT_EXPIRE, 4'd0, 32'd0, 32'd6000));
    // send and free on a slot that is not in use
    issue(make_cmd(ACT_MARK, 4'd15, 32'd0, 32'd7));
    issue(make_cmd(ACT_FREE, 4'd15, 32'd0, 32'd0));
    issue(make_cmd(ACT_FREE, 4'd15, 32'd0, 32'd0));
    // unknown actions
    issue(make_cmd(ACT_UNUSED_LO, 4'd3, 32'd0, 32'd0));
    issue(make_cmd(ACT_UNUSED_HI, 4'd12, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    // release frees the sent slot and keeps the claimed one
    issue(make_cmd(ACT_CLAIM, 4'd0, 32'd0, 32'd0));
    issue(make_cmd(ACT_CLAIM, 4'd0, 32'd0, 32'd0));
    issue(make_cmd(ACT_MARK, 4'd0, 32'd0, 32'd50));
    issue(make_cmd(ACT_RELEASE, 4'd9, 32'd0, 32'd0));

    // largest timeout: only an age of all ones reaches it
    set_timeout(32'hFFFF_FFFF);
    issue(make_cmd(ACT_MARK, 4'd1, 32'd0, 32'h8000_0000));
    issue(make_cmd(ACT_EXPIRE, 4'd0, 32'd0, 32'h7FFF_FFFF));

    // zero timeout: a slot expires on the scan right after its send
    set_timeout(32'd0);
    issue(make_cmd(ACT_CLAIM, 4'd0, 32'd0, 32'd0));
    issue(make_cmd(ACT_MARK, 4'd0, 32'd0, 32'd123));
    issue(make_cmd(ACT_EXPIRE, 4'd0, 32'd0, 32'd123));
    id_guess = 32'd6;

    // random phases, each under its own timeout; the last one without gaps
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin timeout_pick = TIMEOUT_RESET; step = 1500; end
        1: begin timeout_pick = 32'd1;         step = 3;    end
        2: begin timeout_pick = 32'hFFFF_FFFF; step = 2000; end
        3: begin
          timeout_pick = $urandom_range(50, 200000);
          step = timeout_pick / 3 + 1;
        end
        default: begin timeout_pick = 32'd300; step = 200; end
      endcase
      set_timeout(timeout_pick);
      idle_on = (phase != PHASES - 1);
      if (phase == 0 || phase == 2 || phase == 3) flood();
      for (int n = 0; n < SINGLES_PER_PHASE; n++) random_single(step);
    end

    settle();
    if (mismatches == 0) begin
      $display("** ack_pending_slot_table_unit: PASSED **");
    end else begin
      $display("** ack_pending_slot_table_unit: FAILED **");
    end
    $finish;
  end

endmodule

// ===== ack_pending_slot_table_unit.f =====
sv/apst_pkg.sv
sv/apst_cell.sv
sv/apst_ctrl.sv
sv/ack_pending_slot_table_unit.sv
tb/sv/slot_table_checker.sv
tb/sv/ack_pending_slot_table_unit_test.sv
